// File: design/sdtq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdtq_pkg
// Shared types and constants for the sorted deadline timer queue.
// ----------------------------------------------------------------------------
package sdtq_pkg;

  localparam int ID_W      = 4;
  localparam int DLY_W     = 32;
  localparam int NOW_W     = 48;
  localparam int US_PER_MS = 1000;
  localparam int PROD_W    = 42;   // DLY_W plus the bits of US_PER_MS

  typedef enum logic [1:0] {
    OP_ARM    = 2'd0,
    OP_CANCEL = 2'd1,
    OP_EXPIRE = 2'd2,
    OP_QUERY  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    RK_ARMED     = 3'd0,
    RK_CANCELLED = 3'd1,
    RK_FIRED     = 3'd2,
    RK_NONE_DUE  = 3'd3,
    RK_QUERY     = 3'd4
  } kind_t;

  typedef struct packed {
    logic gt;   // entry deadline strictly after the reference time
    logic le;   // entry deadline at or before the reference time
  } cmp_flags_t;

endpackage
`default_nettype wire

// File: design/sdtq_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdtq_in_if / sdtq_out_if
// Valid/ready channels carrying command words and result words.
// ----------------------------------------------------------------------------
interface sdtq_in_if import sdtq_pkg::*; ();
  logic             valid;
  logic             ready;
  op_t              operation;
  logic [ID_W-1:0]  timer_id;
  logic [DLY_W-1:0] delay_ms;
  logic [NOW_W-1:0] now_us;

  modport source (output valid, operation, timer_id, delay_ms, now_us, input ready);
  modport sink   (input valid, operation, timer_id, delay_ms, now_us, output ready);
endinterface

interface sdtq_out_if import sdtq_pkg::*; ();
  logic             valid;
  logic             ready;
  kind_t            result_kind;
  logic [ID_W-1:0]  fired_id;
  logic             found;
  logic [NOW_W-1:0] remaining_us;
  logic             last;

  modport source (output valid, result_kind, fired_id, found, remaining_us, last,
                  input ready);
  modport sink   (input valid, result_kind, fired_id, found, remaining_us, last,
                  output ready);
endinterface
`default_nettype wire

// File: design/sorted_deadline_timer_queue_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_deadline_timer_queue_top
// Up to SLOTS one-shot timers kept in deadline order in a small RAM.
// ----------------------------------------------------------------------------
// Timers sit in RAM entries 0..count-1 in ascending deadline order, ties in
// arming order. A sequencer walks the entries one at a time through a single
// comparator; every entry visited is read and then compared, so the RAM read
// latency sets the pace. Arm runs a removal sweep and then an insertion sweep
// from the tail down to its position; cancel and expire run the removal sweep
// only, and query reads the head entry. Expire emits one fired word per due
// timer, earliest first, and stalls while the result register is held. The
// input is taken only between commands; a finished result may still wait in
// the output register while the next command runs.
// ----------------------------------------------------------------------------
module sorted_deadline_timer_queue_top import sdtq_pkg::*; #(
  parameter int SLOTS     = 16,
  parameter int TIME_BITS = 48
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  sdtq_in_if.sink    in_ch,
  sdtq_out_if.source out_ch
);

  localparam int AW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam int EW = ID_W + TIME_BITS;
  localparam int SW = ((TIME_BITS > PROD_W) ? TIME_BITS : PROD_W) + 1;
  localparam logic [TIME_BITS-1:0] TMAX = {TIME_BITS{1'b1}};

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_ADD  = 10'b0000000010,
    S_RD   = 10'b0000000100,
    S_EV   = 10'b0000001000,
    S_INS  = 10'b0000010000,
    S_IRD  = 10'b0000100000,
    S_IEV  = 10'b0001000000,
    S_QRD  = 10'b0010000000,
    S_QEV  = 10'b0100000000,
    S_DONE = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [CW-1:0]        idx_r, idx_nxt;
  logic [CW-1:0]        drop_r, drop_nxt;
  logic                 pend_r, pend_nxt;
  logic [ID_W-1:0]      pend_id_r, pend_id_nxt;
  logic                 found_r, found_nxt;
  op_t                  op_r, op_nxt;
  logic [ID_W-1:0]      id_r, id_nxt;
  logic [TIME_BITS-1:0] now_r, now_nxt;
  logic [PROD_W-1:0]    prod_r, prod_nxt;
  logic [TIME_BITS-1:0] dl_r, dl_nxt;
  logic [TIME_BITS-1:0] rem_r, rem_nxt;

  logic                 ov_r;
  kind_t                o_kind_r;
  logic [ID_W-1:0]      o_id_r;
  logic                 o_found_r;
  logic [NOW_W-1:0]     o_rem_r;
  logic                 o_last_r;

  logic                 o_ld;
  kind_t                ld_kind;
  logic [ID_W-1:0]      ld_id;
  logic                 ld_found;
  logic [NOW_W-1:0]     ld_rem;
  logic                 ld_last;

  logic                 in_acc, out_free;
  logic [TIME_BITS-1:0] now_sat;
  logic [SW-1:0]        sum;
  logic [TIME_BITS-1:0] dl_sat;

  logic                 we;
  logic [AW-1:0]        waddr, raddr;
  logic [EW-1:0]        wdata, rdata;
  logic [ID_W-1:0]      rd_slot;
  logic [TIME_BITS-1:0] rd_dl;
  logic [CW-1:0]        wr_down, rd_back;

  logic [TIME_BITS-1:0] cmp_ref, cmp_diff;
  cmp_flags_t           cmp_flags;
  logic                 hit, stall;

  // --------------------------------------------------------------------------
  // Input time handling
  // --------------------------------------------------------------------------
  generate
    if (TIME_BITS < NOW_W) begin : g_now_sat
      assign now_sat = (|in_ch.now_us[NOW_W-1:TIME_BITS]) ? TMAX
                                                          : in_ch.now_us[TIME_BITS-1:0];
    end else begin : g_now_ext
      assign now_sat = TIME_BITS'(in_ch.now_us);
    end
  endgenerate

  assign sum    = SW'(now_r) + SW'(prod_r);
  assign dl_sat = (|sum[SW-1:TIME_BITS]) ? TMAX : sum[TIME_BITS-1:0];

  // --------------------------------------------------------------------------
  // Entry store and shared compare unit
  // --------------------------------------------------------------------------
  assign rd_slot = rdata[EW-1:TIME_BITS];
  assign rd_dl   = rdata[TIME_BITS-1:0];
  assign wr_down = idx_r - drop_r;
  assign rd_back = idx_r - CW'(1);
  assign raddr   = (state_r == S_IRD || state_r == S_IEV) ? rd_back[AW-1:0]
                                                          : idx_r[AW-1:0];

  sdtq_ram #(
    .WIDTH (EW),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign cmp_ref = (state_r == S_IEV) ? dl_r : now_r;

  sdtq_cmp #(
    .W (TIME_BITS)
  ) u_cmp (
    .x     (rd_dl),
    .y     (cmp_ref),
    .diff  (cmp_diff),
    .flags (cmp_flags)
  );

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_free = !ov_r || out_ch.ready;
  assign hit      = (op_r == OP_EXPIRE) ? cmp_flags.le : (rd_slot == id_r);
  assign stall    = hit && (op_r == OP_EXPIRE) && pend_r && !out_free;

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    idx_nxt     = idx_r;
    drop_nxt    = drop_r;
    pend_nxt    = pend_r;
    pend_id_nxt = pend_id_r;
    found_nxt   = found_r;
    op_nxt      = op_r;
    id_nxt      = id_r;
    now_nxt     = now_r;
    prod_nxt    = prod_r;
    dl_nxt      = dl_r;
    rem_nxt     = rem_r;
    we          = 1'b0;
    waddr       = '0;
    wdata       = '0;
    o_ld        = 1'b0;
    ld_kind     = RK_ARMED;
    ld_id       = '0;
    ld_found    = 1'b0;
    ld_rem      = '0;
    ld_last     = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_nxt    = in_ch.operation;
          id_nxt    = in_ch.timer_id;
          now_nxt   = now_sat;
          prod_nxt  = PROD_W'(in_ch.delay_ms) * PROD_W'(US_PER_MS);
          idx_nxt   = '0;
          drop_nxt  = '0;
          pend_nxt  = 1'b0;
          found_nxt = 1'b0;
          rem_nxt   = '0;
          case (in_ch.operation)
            OP_ARM:   state_nxt = S_ADD;
            OP_QUERY: state_nxt = S_QRD;
            default:  state_nxt = S_RD;
          endcase
        end
      end

      S_ADD: begin
        dl_nxt    = dl_sat;
        state_nxt = S_RD;
      end

      // Upward sweep: drop matching entries, slide the rest down over them.
      S_RD: begin
        if (idx_r == cnt_r) begin
          cnt_nxt   = cnt_r - drop_r;
          found_nxt = (drop_r != '0);
          state_nxt = (op_r == OP_ARM) ? S_INS : S_DONE;
        end else begin
          state_nxt = S_EV;
        end
      end

      S_EV: begin
        if (!stall) begin
          if (hit) begin
            drop_nxt = drop_r + CW'(1);
            if (op_r == OP_EXPIRE) begin
              if (pend_r) begin
                o_ld    = 1'b1;
                ld_kind = RK_FIRED;
                ld_id   = pend_id_r;
              end
              pend_nxt    = 1'b1;
              pend_id_nxt = rd_slot;
            end
          end else if (drop_r != '0) begin
            we    = 1'b1;
            waddr = wr_down[AW-1:0];
            wdata = rdata;
          end
          idx_nxt   = idx_r + CW'(1);
          state_nxt = S_RD;
        end
      end

      S_INS: begin
        if (cnt_r == CW'(SLOTS)) begin
          found_nxt = 1'b0;
          state_nxt = S_DONE;
        end else begin
          found_nxt = 1'b1;
          idx_nxt   = cnt_r;
          state_nxt = S_IRD;
        end
      end

      // Downward sweep: shift later deadlines up, drop the new one in the gap.
      S_IRD: begin
        if (idx_r == '0) begin
          we        = 1'b1;
          waddr     = '0;
          wdata     = {id_r, dl_r};
          cnt_nxt   = cnt_r + CW'(1);
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_IEV;
        end
      end

      S_IEV: begin
        we    = 1'b1;
        waddr = idx_r[AW-1:0];
        if (cmp_flags.gt) begin
          wdata     = rdata;
          idx_nxt   = rd_back;
          state_nxt = S_IRD;
        end else begin
          wdata     = {id_r, dl_r};
          cnt_nxt   = cnt_r + CW'(1);
          state_nxt = S_DONE;
        end
      end

      S_QRD: begin
        state_nxt = (cnt_r == '0) ? S_DONE : S_QEV;
      end

      S_QEV: begin
        found_nxt = 1'b1;
        rem_nxt   = cmp_flags.gt ? cmp_diff : '0;
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (out_free) begin
          o_ld    = 1'b1;
          ld_last = 1'b1;
          case (op_r)
            OP_ARM: begin
              ld_kind  = RK_ARMED;
              ld_id    = id_r;
              ld_found = found_r;
            end
            OP_CANCEL: begin
              ld_kind  = RK_CANCELLED;
              ld_id    = id_r;
              ld_found = found_r;
            end
            OP_EXPIRE: begin
              ld_kind = pend_r ? RK_FIRED : RK_NONE_DUE;
              ld_id   = pend_r ? pend_id_r : '0;
            end
            default: begin
              ld_kind  = RK_QUERY;
              ld_found = found_r;
              ld_rem   = NOW_W'(rem_r);
            end
          endcase
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      idx_r   <= '0;
      drop_r  <= '0;
      pend_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      idx_r   <= idx_nxt;
      drop_r  <= drop_nxt;
      pend_r  <= pend_nxt;
      if (o_ld) begin
        ov_r <= 1'b1;
      end else if (out_ch.ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_id_r <= pend_id_nxt;
    found_r   <= found_nxt;
    op_r      <= op_nxt;
    id_r      <= id_nxt;
    now_r     <= now_nxt;
    prod_r    <= prod_nxt;
    dl_r      <= dl_nxt;
    rem_r     <= rem_nxt;
    if (o_ld) begin
      o_kind_r  <= ld_kind;
      o_id_r    <= ld_id;
      o_found_r <= ld_found;
      o_rem_r   <= ld_rem;
      o_last_r  <= ld_last;
    end
  end

  assign in_ch.ready         = (state_r == S_IDLE);
  assign out_ch.valid        = ov_r;
  assign out_ch.result_kind  = o_kind_r;
  assign out_ch.fired_id     = o_id_r;
  assign out_ch.found        = o_found_r;
  assign out_ch.remaining_us = o_rem_r;
  assign out_ch.last         = o_last_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(SLOTS))
    else $error("timer count beyond capacity");

  a_drop_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD || state_r == S_EV) |-> drop_r <= idx_r)
    else $error("more entries dropped than visited");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("command taken while previous one still running");

  a_query_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_QRD || state_r == S_QEV) |-> !we)
    else $error("entry store written during query");

endmodule
`default_nettype wire

// File: design/sdtq_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdtq_ram
// Generic RAM: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module sdtq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// File: design/sdtq_cmp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdtq_cmp
// Shared subtract/compare unit: entry deadline against a reference time.
// ----------------------------------------------------------------------------
module sdtq_cmp import sdtq_pkg::*; #(
  parameter int W = 48
) (
  input  wire logic [W-1:0] x,
  input  wire logic [W-1:0] y,
  output logic      [W-1:0] diff,
  output cmp_flags_t        flags
);

  logic [W:0] d;

  assign d        = {1'b0, x} - {1'b0, y};
  assign diff     = d[W-1:0];
  assign flags.gt = !d[W] && (|d[W-1:0]);
  assign flags.le = !flags.gt;

endmodule
`default_nettype wire

// File: test/sdtq_timer_monitor.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdtq_timer_monitor
// Watches both channels of the timer queue, predicts every result word from
// its own deadline-ordered copy of the timers and compares field by field.
// ----------------------------------------------------------------------------
module sdtq_timer_monitor import sdtq_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  sdtq_in_if        in_mon,
  sdtq_out_if       out_mon,
  output int        mismatches,
  output int        pending
);

  localparam int TIMERS     = 16;
  localparam int SUM_W      = NOW_W + 1;
  localparam int MS_TO_US   = 1000;
  localparam int PRINT_CAP  = 100;

  typedef struct {
    kind_t            kind;
    logic [ID_W-1:0]  id;
    logic             found;
    logic [NOW_W-1:0] rem;
    logic             last;
  } result_word_t;

  // timers in deadline order, ties in arming order
  logic [ID_W-1:0]  chain_id [TIMERS];
  logic [NOW_W-1:0] chain_dl [TIMERS];
  int               chain_len;

  result_word_t     expected_words [$];

  initial begin
    mismatches = 0;
    pending    = 0;
    chain_len  = 0;
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= PRINT_CAP) $display("%0t: mismatch: %s", $time, msg);
  endtask

  function automatic void queue_word(kind_t k, logic [ID_W-1:0] id, logic found,
                                     logic [NOW_W-1:0] rem, logic last);
    result_word_t w;
    w.kind  = k;
    w.id    = id;
    w.found = found;
    w.rem   = rem;
    w.last  = last;
    expected_words.push_back(w);
  endfunction

  function automatic int chain_find(logic [ID_W-1:0] id);
    for (int i = 0; i < chain_len; i++)
      if (chain_id[i] == id) return i;
    return -1;
  endfunction

  function automatic void chain_drop(int pos);
    for (int i = pos; i + 1 < chain_len; i++) begin
      chain_id[i] = chain_id[i+1];
      chain_dl[i] = chain_dl[i+1];
    end
    chain_len--;
  endfunction

  function automatic logic chain_insert(logic [ID_W-1:0] id, logic [NOW_W-1:0] dl);
    int pos;
    if (chain_len >= TIMERS) return 1'b0;
    pos = 0;
    // go past every entry due at or before the new deadline
    while (pos < chain_len && chain_dl[pos] <= dl) pos++;
    for (int i = chain_len; i > pos; i--) begin
      chain_id[i] = chain_id[i-1];
      chain_dl[i] = chain_dl[i-1];
    end
    chain_id[pos] = id;
    chain_dl[pos] = dl;
    chain_len++;
    return 1'b1;
  endfunction

  function automatic void predict_command(op_t op, logic [ID_W-1:0] id,
                                          logic [DLY_W-1:0] dly, logic [NOW_W-1:0] now);
    logic [SUM_W-1:0] sum;
    logic [NOW_W-1:0] dl;
    int               pos;
    int               fired;
    logic             ok;
    case (op)
      OP_ARM: begin
        sum = SUM_W'(now) + SUM_W'(dly) * SUM_W'(MS_TO_US);
        // saturate a deadline past the end of the time range
        dl  = sum[NOW_W] ? '1 : sum[NOW_W-1:0];
        pos = chain_find(id);
        if (pos >= 0) chain_drop(pos);
        ok = chain_insert(id, dl);
        queue_word(RK_ARMED, id, ok, '0, 1'b1);
      end
      OP_CANCEL: begin
        pos = chain_find(id);
        if (pos >= 0) chain_drop(pos);
        queue_word(RK_CANCELLED, id, pos >= 0, '0, 1'b1);
      end
      OP_EXPIRE: begin
        fired = 0;
        while (chain_len > 0 && chain_dl[0] <= now) begin
          queue_word(RK_FIRED, chain_id[0], 1'b0, '0, 1'b0);
          chain_drop(0);
          fired++;
        end
        if (fired == 0) queue_word(RK_NONE_DUE, '0, 1'b0, '0, 1'b1);
        else expected_words[expected_words.size()-1].last = 1'b1;
      end
      default: begin
        if (chain_len == 0) queue_word(RK_QUERY, '0, 1'b0, '0, 1'b1);
        else queue_word(RK_QUERY, '0, 1'b1,
                        (chain_dl[0] > now) ? chain_dl[0] - now : '0, 1'b1);
      end
    endcase
  endfunction

  task automatic check_word();
    result_word_t w;
    if (expected_words.size() == 0) begin
      report_mismatch("result word with nothing expected");
    end else begin
      w = expected_words.pop_front();
      if (out_mon.result_kind !== w.kind)
        report_mismatch($sformatf("result_kind %0d, want %0d",
                                  out_mon.result_kind, w.kind));
      if (out_mon.fired_id !== w.id)
        report_mismatch($sformatf("fired_id %0d, want %0d", out_mon.fired_id, w.id));
      if (out_mon.found !== w.found)
        report_mismatch($sformatf("found %b, want %b", out_mon.found, w.found));
      if (out_mon.remaining_us !== w.rem)
        report_mismatch($sformatf("remaining_us %0d, want %0d",
                                  out_mon.remaining_us, w.rem));
      if (out_mon.last !== w.last)
        report_mismatch($sformatf("last %b, want %b", out_mon.last, w.last));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      chain_len = 0;
      expected_words.delete();
    end else begin
      if (in_mon.valid && in_mon.ready)
        predict_command(in_mon.operation, in_mon.timer_id, in_mon.delay_ms,
                        in_mon.now_us);
      if (out_mon.valid && out_mon.ready) check_word();
    end
    pending <= expected_words.size();
  end

endmodule
`default_nettype wire

// File: test/tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb
// Drives arm, cancel, expire and query commands into the timer queue: a
// directed set of corner cases, then random commands against a moving clock.
// ----------------------------------------------------------------------------
module tb;
  import sdtq_pkg::*;

  localparam int HALF_PERIOD     = 5;
  localparam int RESET_CYCLES    = 12;
  localparam int RANDOM_ITEMS    = 150;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_CYCLES    = 100;
  localparam int LIMIT_CYCLES    = 200000;

  logic clk = 1'b0;
  logic rst_n;
  int   mismatches;
  int   pending;
  int   cycle_cnt = 0;
  logic no_idle = 1'b0;
  int   hold_off_requests = 0;
  int   hold_off_served = 0;

  sdtq_in_if  cmd_ch ();
  sdtq_out_if res_ch ();

  sorted_deadline_timer_queue_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (cmd_ch),
    .out_ch (res_ch)
  );

  sdtq_timer_monitor mon (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (cmd_ch),
    .out_mon    (res_ch),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always #(HALF_PERIOD) clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // result side: random back-pressure plus an occasional long hold-off
  initial begin
    res_ch.ready = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_off_served != hold_off_requests) begin
        hold_off_served++;
        res_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      res_ch.ready <= no_idle || ($urandom_range(99) >= 14);
      @(posedge clk);
    end
  end

  task automatic send_cmd(input op_t op, input logic [ID_W-1:0] id,
                          input logic [DLY_W-1:0] dly, input logic [NOW_W-1:0] now);
    while (!no_idle && $urandom_range(99) < 14) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid     <= 1'b1;
    cmd_ch.operation <= op;
    cmd_ch.timer_id  <= id;
    cmd_ch.delay_ms  <= dly;
    cmd_ch.now_us    <= now;
    do @(posedge clk); while (!cmd_ch.ready);
  endtask

  // drop valid and hold until every predicted word has come back
  task automatic wait_all_results();
    cmd_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    logic [NOW_W-1:0] t0;
    logic [NOW_W-1:0] wall_us;
    logic [NOW_W-1:0] now;
    logic [DLY_W-1:0] dly;
    logic [ID_W-1:0]  id;
    int               pick;
    op_t              op;

    rst_n            = 1'b0;
    cmd_ch.valid     = 1'b0;
    cmd_ch.operation = OP_ARM;
    cmd_ch.timer_id  = '0;
    cmd_ch.delay_ms  = '0;
    cmd_ch.now_us    = '0;
    t0               = 48'd1_000_000;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty queue behavior
    send_cmd(OP_QUERY,  4'd0, 32'd0, '0);
    send_cmd(OP_EXPIRE, 4'd0, 32'd0, '0);
    send_cmd(OP_CANCEL, 4'd5, 32'd0, '0);
    // zero delay, and a deadline that overflows the time range
    send_cmd(OP_ARM, 4'd0,  32'd0, '0);
    send_cmd(OP_ARM, 4'd15, '1, '1);
    // re-arm replaces the earlier deadline
    send_cmd(OP_ARM, 4'd3, 32'd5, t0);
    send_cmd(OP_ARM, 4'd3, 32'd1, t0);
    // head already past due, then a live head after cancel
    send_cmd(OP_QUERY,  4'd0, 32'd0, t0);
    send_cmd(OP_CANCEL, 4'd0, 32'd0, t0);
    send_cmd(OP_QUERY,  4'd0, 32'd0, t0);
    // deadline equal to now fires
    send_cmd(OP_EXPIRE, 4'd0, 32'd0, t0 + 48'd1000);
    send_cmd(OP_EXPIRE, 4'd0, 32'd0, '1);
    // fill every slot with ties, then fire them all in one sweep
    for (int i = 0; i < 16; i++)
      send_cmd(OP_ARM, ID_W'(i), DLY_W'(i % 4), t0);
    send_cmd(OP_EXPIRE, 4'd0, 32'd0, t0 + 48'd3000);
    wait_all_results();

    wall_us = t0 + 48'd5000;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      no_idle = (n >= 60 && n < 100);
      if (n == 110) hold_off_requests++;
      if (n == 130) wait_all_results();
      wall_us = wall_us + NOW_W'($urandom_range(2500));
      pick    = $urandom_range(99);
      id      = ID_W'($urandom_range(15));
      dly     = ($urandom_range(9) == 0) ? $urandom() : DLY_W'($urandom_range(20));
      now     = ($urandom_range(19) == 0) ? NOW_W'({$urandom(), $urandom()}) : wall_us;
      if (pick < 40)      op = OP_ARM;
      else if (pick < 55) op = OP_CANCEL;
      else if (pick < 80) op = OP_EXPIRE;
      else                op = OP_QUERY;
      send_cmd(op, id, dly, now);
    end
    no_idle = 1'b0;

    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: sorted_deadline_timer_queue_top.f
design/sdtq_pkg.sv
design/sdtq_if.sv
design/sdtq_ram.sv
design/sdtq_cmp.sv
design/sorted_deadline_timer_queue_top.sv
test/sdtq_timer_monitor.sv
test/tb.sv
